/* sv/rrhf_pkg.sv */
// ----------------------------------------------------------------------------
// rrhf_pkg: shared types and constants for the rectangle remainder unit
// Coordinate, rectangle, area and beat types, plus the zero rectangle and the
// width helper used by both datapath stages.
// ----------------------------------------------------------------------------
package rrhf_pkg;

  // Coordinate width of all rectangle corners
  localparam int COORD_BITS = 16;
  // Width/height of an inclusive rectangle spans up to 2^COORD_BITS either way
  localparam int DIM_W      = COORD_BITS + 2;
  // Exact signed product of two dimensions
  localparam int AREA_W     = 2 * DIM_W;
  // Minimum hit-size register
  localparam int FLOOR_BITS = 12;
  // Common width for comparing a dimension against the unsigned floor
  localparam int CMP_W      = (DIM_W > FLOOR_BITS + 1) ? DIM_W : FLOOR_BITS + 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIM_W-1:0]      dim_t;
  typedef logic signed [AREA_W-1:0]     area_t;
  typedef logic        [FLOOR_BITS-1:0] floor_t;

  localparam floor_t FLOOR_RESET = floor_t'(44);
  localparam coord_t COORD_ONE   = coord_t'(1);

  typedef struct packed {
    coord_t left;
    coord_t top;
    coord_t right;
    coord_t bottom;
  } rect_t;

  // Remainder used when the cover leaves no slice of the object
  localparam rect_t ZERO_RECT = '{left: '0, top: '0, right: '1, bottom: '1};

  // Input beat
  typedef struct packed {
    coord_t obj_left;
    coord_t obj_top;
    coord_t obj_right;
    coord_t obj_bottom;
    coord_t cover_left;
    coord_t cover_top;
    coord_t cover_right;
    coord_t cover_bottom;
  } in_item_t;

  // Result beat
  typedef struct packed {
    coord_t rem_left;
    coord_t rem_top;
    coord_t rem_right;
    coord_t rem_bottom;
    logic   clears_floor;
  } out_item_t;

  // One candidate slice with its area
  typedef struct packed {
    logic  vld;
    rect_t rect;
    area_t area;
  } cand_t;

  // Slice order: above, below, left, right
  localparam int NUM_CAND = 4;
  typedef cand_t [NUM_CAND-1:0] cand_set_t;

  // Inclusive width (right - left + 1), exact
  function automatic dim_t span(input coord_t lo, input coord_t hi);
    dim_t lo_d;
    dim_t hi_d;
    lo_d = dim_t'(lo);
    hi_d = dim_t'(hi);
    return hi_d - lo_d + dim_t'(1);
  endfunction

endpackage

/* sv/rrhf_slice.sv */
// ----------------------------------------------------------------------------
// rrhf_slice: overlap test, slice forming and slice areas
// Builds the four candidate slices of the object around the cover and their
// exact signed areas. Without overlap only the first candidate is valid and
// carries the object itself.
// ----------------------------------------------------------------------------
module rrhf_slice (
  input  rrhf_pkg::in_item_t  item,
  output rrhf_pkg::cand_set_t cands
);

  rrhf_pkg::rect_t obj;
  rrhf_pkg::rect_t cov;
  rrhf_pkg::rect_t slice_rect [rrhf_pkg::NUM_CAND];
  logic            slice_vld  [rrhf_pkg::NUM_CAND];
  logic            overlap;

  // Unpack corners
  assign obj = '{left: item.obj_left, top: item.obj_top,
                 right: item.obj_right, bottom: item.obj_bottom};
  assign cov = '{left: item.cover_left, top: item.cover_top,
                 right: item.cover_right, bottom: item.cover_bottom};

  // Inclusive overlap test
  assign overlap = (obj.left <= cov.right) && (cov.left <= obj.right) &&
                   (obj.top <= cov.bottom) && (cov.top <= obj.bottom);

  // Form slices above, below, left and right of the cover
  always_comb begin
    slice_rect[0]        = obj;
    slice_rect[0].bottom = cov.top - rrhf_pkg::COORD_ONE;
    slice_rect[1]        = obj;
    slice_rect[1].top    = cov.bottom + rrhf_pkg::COORD_ONE;
    slice_rect[2]        = obj;
    slice_rect[2].right  = cov.left - rrhf_pkg::COORD_ONE;
    slice_rect[3]        = obj;
    slice_rect[3].left   = cov.right + rrhf_pkg::COORD_ONE;

    slice_vld[0] = cov.top > obj.top;
    slice_vld[1] = cov.bottom < obj.bottom;
    slice_vld[2] = cov.left > obj.left;
    slice_vld[3] = cov.right < obj.right;

    // No overlap: the object passes as the only candidate
    if (!overlap) begin
      slice_rect[0] = obj;
      slice_vld[0]  = 1'b1;
      slice_vld[1]  = 1'b0;
      slice_vld[2]  = 1'b0;
      slice_vld[3]  = 1'b0;
    end
  end

  // One multiplier per candidate
  always_comb begin
    for (int i = 0; i < rrhf_pkg::NUM_CAND; i++) begin
      cands[i].vld  = slice_vld[i];
      cands[i].rect = slice_rect[i];
      cands[i].area =
        rrhf_pkg::area_t'(rrhf_pkg::span(slice_rect[i].left, slice_rect[i].right)) *
        rrhf_pkg::area_t'(rrhf_pkg::span(slice_rect[i].top, slice_rect[i].bottom));
    end
  end

endmodule

/* sv/rrhf_pick.sv */
// ----------------------------------------------------------------------------
// rrhf_pick: largest-slice selection and hit-size check
// Picks the valid candidate with the largest area, earliest on a tie, falls
// back to the zero rectangle, and compares its width and height to the floor.
// ----------------------------------------------------------------------------
module rrhf_pick (
  input  rrhf_pkg::cand_set_t cands,
  input  rrhf_pkg::floor_t    min_hit_size,
  output rrhf_pkg::out_item_t result
);

  rrhf_pkg::cand_t win_lo;
  rrhf_pkg::cand_t win_hi;
  rrhf_pkg::cand_t win;
  rrhf_pkg::rect_t rem;
  logic signed [rrhf_pkg::CMP_W-1:0] rem_w;
  logic signed [rrhf_pkg::CMP_W-1:0] rem_h;
  logic signed [rrhf_pkg::CMP_W-1:0] floor_c;

  // Later candidate wins only with a strictly larger area
  function automatic rrhf_pkg::cand_t keep(input rrhf_pkg::cand_t a,
                                           input rrhf_pkg::cand_t b);
    if (b.vld && (!a.vld || (b.area > a.area))) begin
      return b;
    end
    return a;
  endfunction

  // Two-level tournament keeps earliest-wins ordering
  assign win_lo = keep(cands[0], cands[1]);
  assign win_hi = keep(cands[2], cands[3]);
  assign win    = keep(win_lo, win_hi);

  assign rem = win.vld ? win.rect : rrhf_pkg::ZERO_RECT;

  // Hit-size check on the chosen remainder
  assign rem_w   = rrhf_pkg::CMP_W'(rrhf_pkg::span(rem.left, rem.right));
  assign rem_h   = rrhf_pkg::CMP_W'(rrhf_pkg::span(rem.top, rem.bottom));
  assign floor_c = rrhf_pkg::CMP_W'({1'b0, min_hit_size});

  assign result.rem_left     = rem.left;
  assign result.rem_top      = rem.top;
  assign result.rem_right    = rem.right;
  assign result.rem_bottom   = rem.bottom;
  assign result.clears_floor = (rem_w >= floor_c) && (rem_h >= floor_c);

endmodule

/* sv/rect_remainder_hit_floor_unit.sv */
// ----------------------------------------------------------------------------
// rect_remainder_hit_floor_unit: remainder of an object after a cover
// Top level: input register, slice/area stage, pick stage, result register.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat carries an object and a cover rectangle (inclusive
//           corners). A beat is taken when in_valid is high and in_stall low.
//   out_* : one beat per input beat with the largest remaining slice and the
//           clears_floor flag, taken when out_valid is high and out_stall low.
//   cfg_* : writes min_hit_size (cfg_ready is always high); write only while
//           no beats are in flight.
//   From input acceptance to out_valid a beat passes the input register, the
//   area register (after the four slice multipliers) and the result register.
//   Throughput is one beat per cycle while out_stall is low. Each stage loads
//   when it is empty or its successor moves, so bubbles close up; in_stall
//   rises only when all three stages hold beats and out_stall is high.
//   A stalled result holds its payload while earlier stages keep filling.
//   Reset (rst_n low, synchronous) empties the pipeline and sets
//   min_hit_size to 44.
// ----------------------------------------------------------------------------
module rect_remainder_hit_floor_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  rrhf_pkg::in_item_t    in_item,
  // Result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output rrhf_pkg::out_item_t   out_item,
  // Configuration channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  rrhf_pkg::floor_t      cfg_min_hit_size
);

  rrhf_pkg::in_item_t  in_item_r;
  logic                in_vld_r;
  rrhf_pkg::cand_set_t cand_nxt;
  rrhf_pkg::cand_set_t cand_r;
  logic                cand_vld_r;
  rrhf_pkg::out_item_t out_nxt;
  rrhf_pkg::out_item_t out_item_r;
  logic                out_vld_r;
  rrhf_pkg::floor_t    floor_r;
  logic                adv_out;
  logic                adv_cand;
  logic                adv_in;

  // Stage advance: load when empty or when the next stage moves
  assign adv_out  = !out_vld_r || !out_stall;
  assign adv_cand = !cand_vld_r || adv_out;
  assign adv_in   = !in_vld_r || adv_cand;

  assign in_stall  = !adv_in;
  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;
  assign cfg_ready = 1'b1;

  // Hold the hit-size floor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_r <= rrhf_pkg::FLOOR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      floor_r <= cfg_min_hit_size;
    end
  end

  // Valid bits of the three stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      cand_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (adv_in) begin
        in_vld_r <= in_valid;
      end
      if (adv_cand) begin
        cand_vld_r <= in_vld_r;
      end
      if (adv_out) begin
        out_vld_r <= cand_vld_r;
      end
    end
  end

  // Payload registers advance with their stage
  always_ff @(posedge clk) begin
    if (adv_in && in_valid) begin
      in_item_r <= in_item;
    end
    if (adv_cand && in_vld_r) begin
      cand_r <= cand_nxt;
    end
    if (adv_out && cand_vld_r) begin
      out_item_r <= out_nxt;
    end
  end

  rrhf_slice u_slice (
    .item  (in_item_r),
    .cands (cand_nxt)
  );

  rrhf_pick u_pick (
    .cands        (cand_r),
    .min_hit_size (floor_r),
    .result       (out_nxt)
  );

  // The input is held off only when every stage is full and the output stalls
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_vld_r && cand_vld_r && out_vld_r && out_stall))
    else $error("in_stall raised with room in the pipeline");

  // A new result appears only from a filled area stage
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(cand_vld_r))
    else $error("result appeared without a beat in the area stage");

  // A nonzero floor that is cleared implies a non-inverted width
  a_floor_width: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_item_r.clears_floor && (floor_r != '0)) |->
      (out_item_r.rem_right >= out_item_r.rem_left))
    else $error("clears_floor set on an inverted remainder");

  // A configuration write lands in the floor register
  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready) |=> (floor_r == $past(cfg_min_hit_size)))
    else $error("min_hit_size write lost");

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: rect_remainder_hit_floor_unit check
// Sends object/cover rectangle pairs through the unit with bursty input and
// random output stalls. A local model predicts each remainder rectangle and
// its clears_floor flag, and every result beat is checked field by field.
// The min_hit_size register is rewritten between phases, extremes included.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int CYCLE_LIMIT      = 400000;
  localparam int ITEMS_PER_PHASE  = 350;
  localparam int PIPE_DRAIN       = 4;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  rrhf_pkg::in_item_t  in_item;
  logic                out_valid;
  logic                out_stall;
  rrhf_pkg::out_item_t out_item;
  logic                cfg_valid;
  logic                cfg_ready;
  rrhf_pkg::floor_t    cfg_min_hit_size;

  // Queries waiting to be sent and remainders waiting to come back
  rrhf_pkg::in_item_t  pending_queries [$];
  rrhf_pkg::out_item_t expected_remainders [$];

  rrhf_pkg::floor_t floor_model;
  int     error_count;
  int     results_checked;
  int     floor_clears;
  int     empty_remainders;
  int     settings_used;
  int     cycle_count;
  int     burst_left;
  int     gap_left;
  int     stall_mode;
  int     stall_mode_left;

  rect_remainder_hit_floor_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_item          (in_item),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_item         (out_item),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_min_hit_size (cfg_min_hit_size)
  );

  // 20 ns clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Remainder of the object after the cover, slices tried above, below,
  // left, right; the first slice of largest signed area wins
  function automatic rrhf_pkg::out_item_t predict_remainder(rrhf_pkg::in_item_t q,
                                                            rrhf_pkg::floor_t fl);
    longint o_l, o_t, o_r, o_b, c_l, c_t, c_r, c_b;
    longint s_l [4];
    longint s_t [4];
    longint s_r [4];
    longint s_b [4];
    longint r_l, r_t, r_r, r_b, top_area, this_area, wid, hgt;
    int n;
    rrhf_pkg::out_item_t res;
    o_l = longint'(q.obj_left);
    o_t = longint'(q.obj_top);
    o_r = longint'(q.obj_right);
    o_b = longint'(q.obj_bottom);
    c_l = longint'(q.cover_left);
    c_t = longint'(q.cover_top);
    c_r = longint'(q.cover_right);
    c_b = longint'(q.cover_bottom);
    r_l = o_l;
    r_t = o_t;
    r_r = o_r;
    r_b = o_b;
    if (o_l <= c_r && c_l <= o_r && o_t <= c_b && c_t <= o_b) begin
      n = 0;
      for (int i = 0; i < 4; i++) begin
        s_l[i] = o_l;
        s_t[i] = o_t;
        s_r[i] = o_r;
        s_b[i] = o_b;
      end
      if (c_t > o_t) begin
        s_b[n] = c_t - 1;
        n++;
      end
      if (c_b < o_b) begin
        s_t[n] = c_b + 1;
        n++;
      end
      if (c_l > o_l) begin
        s_r[n] = c_l - 1;
        n++;
      end
      if (c_r < o_r) begin
        s_l[n] = c_r + 1;
        n++;
      end
      if (n == 0) begin
        r_l = 0;
        r_t = 0;
        r_r = -1;
        r_b = -1;
      end else begin
        top_area = 0;
        for (int i = 0; i < n; i++) begin
          this_area = (s_r[i] - s_l[i] + 1) * (s_b[i] - s_t[i] + 1);
          if (i == 0 || this_area > top_area) begin
            top_area = this_area;
            r_l = s_l[i];
            r_t = s_t[i];
            r_r = s_r[i];
            r_b = s_b[i];
          end
        end
      end
    end
    wid = r_r - r_l + 1;
    hgt = r_b - r_t + 1;
    res.rem_left     = rrhf_pkg::coord_t'(r_l);
    res.rem_top      = rrhf_pkg::coord_t'(r_t);
    res.rem_right    = rrhf_pkg::coord_t'(r_r);
    res.rem_bottom   = rrhf_pkg::coord_t'(r_b);
    res.clears_floor = (wid >= longint'(fl)) && (hgt >= longint'(fl));
    return res;
  endfunction

  function automatic rrhf_pkg::in_item_t pack_query(int ol, int ot, int orr, int ob,
                                                    int cl, int ct, int cr, int cb);
    rrhf_pkg::in_item_t q;
    q.obj_left     = rrhf_pkg::coord_t'(ol);
    q.obj_top      = rrhf_pkg::coord_t'(ot);
    q.obj_right    = rrhf_pkg::coord_t'(orr);
    q.obj_bottom   = rrhf_pkg::coord_t'(ob);
    q.cover_left   = rrhf_pkg::coord_t'(cl);
    q.cover_top    = rrhf_pkg::coord_t'(ct);
    q.cover_right  = rrhf_pkg::coord_t'(cr);
    q.cover_bottom = rrhf_pkg::coord_t'(cb);
    return q;
  endfunction

  function automatic int pick(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic rrhf_pkg::coord_t corner_coord();
    case ($urandom_range(0, 6))
      0:       return rrhf_pkg::coord_t'(-32768);
      1:       return rrhf_pkg::coord_t'(-32767);
      2:       return rrhf_pkg::coord_t'(-1);
      3:       return rrhf_pkg::coord_t'(0);
      4:       return rrhf_pkg::coord_t'(1);
      5:       return rrhf_pkg::coord_t'(32766);
      default: return rrhf_pkg::coord_t'(32767);
    endcase
  endfunction

  // Mostly overlapping pairs sized around the floor, then near misses,
  // inverted corners, range extremes and raw random words
  function automatic rrhf_pkg::in_item_t random_query(rrhf_pkg::floor_t fl);
    int kind, reach, x0, y0, w, h, cx, cy, cw, ch;
    rrhf_pkg::coord_t swap;
    rrhf_pkg::in_item_t q;
    kind  = $urandom_range(0, 99);
    reach = 2 * int'(fl) + 16;
    x0 = pick(-32768, 32767);
    y0 = pick(-32768, 32767);
    w  = pick(1, reach);
    h  = pick(1, reach);
    if (kind < 55) begin
      cx = x0 + pick(-w / 2, w - 1);
      cy = y0 + pick(-h / 2, h - 1);
    end else begin
      cx = x0 + pick(-2 * w, 2 * w);
      cy = y0 + pick(-2 * h, 2 * h);
    end
    cw = pick(1, w + w / 2);
    ch = pick(1, h + h / 2);
    q = pack_query(x0, y0, x0 + w - 1, y0 + h - 1, cx, cy, cx + cw - 1, cy + ch - 1);
    if (kind >= 70 && kind < 80) begin
      // flip some corners so widths or heights go negative
      if ($urandom_range(0, 1)) begin
        swap = q.obj_left;
        q.obj_left = q.obj_right;
        q.obj_right = swap;
      end
      if ($urandom_range(0, 1)) begin
        swap = q.obj_top;
        q.obj_top = q.obj_bottom;
        q.obj_bottom = swap;
      end
      if ($urandom_range(0, 1)) begin
        swap = q.cover_left;
        q.cover_left = q.cover_right;
        q.cover_right = swap;
      end
      if ($urandom_range(0, 1)) begin
        swap = q.cover_top;
        q.cover_top = q.cover_bottom;
        q.cover_bottom = swap;
      end
    end else if (kind >= 80 && kind < 90) begin
      q.obj_left     = corner_coord();
      q.obj_top      = corner_coord();
      q.obj_right    = corner_coord();
      q.obj_bottom   = corner_coord();
      q.cover_left   = corner_coord();
      q.cover_top    = corner_coord();
      q.cover_right  = corner_coord();
      q.cover_bottom = corner_coord();
    end else if (kind >= 90) begin
      q = rrhf_pkg::in_item_t'({$urandom, $urandom, $urandom, $urandom});
    end
    return q;
  endfunction

  task automatic report_field(string name, int want_v, int got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want_v, got_v);
      error_count++;
    end
  endtask

  task automatic check_result(rrhf_pkg::out_item_t got);
    rrhf_pkg::out_item_t want;
    if (expected_remainders.size() == 0) begin
      $display("%0t: unexpected result beat, expected none actual %h", $time, got);
      error_count++;
    end else begin
      want = expected_remainders.pop_front();
      report_field("rem_left", want.rem_left, got.rem_left);
      report_field("rem_top", want.rem_top, got.rem_top);
      report_field("rem_right", want.rem_right, got.rem_right);
      report_field("rem_bottom", want.rem_bottom, got.rem_bottom);
      report_field("clears_floor", want.clears_floor, got.clears_floor);
      results_checked++;
      if (want.clears_floor) floor_clears++;
      if ({want.rem_left, want.rem_top, want.rem_right, want.rem_bottom} ==
          rrhf_pkg::ZERO_RECT)
        empty_remainders++;
    end
  endtask

  // Wait until nothing is queued, in flight or expected, then let the pipe drain
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_queries.size() != 0 || in_valid || expected_remainders.size() != 0);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  task automatic write_floor(rrhf_pkg::floor_t value);
    @(posedge clk);
    cfg_valid        <= 1'b1;
    cfg_min_hit_size <= value;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid   <= 1'b0;
    floor_model = value;
    settings_used++;
  endtask

  // Input driver: bursts of beats with random gaps, payload held while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_remainders.push_back(predict_remainder(in_item, floor_model));
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_queries.size() != 0) begin
          in_item  <= pending_queries.pop_front();
          in_valid <= 1'b1;
          burst_left = burst_left - 1;
          if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and stall pattern: free-flowing, light, heavy, alternating
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      check_result(out_item);
    end
    if (stall_mode_left == 0) begin
      stall_mode      = $urandom_range(0, 3);
      stall_mode_left = $urandom_range(8, 80);
    end else begin
      stall_mode_left = stall_mode_left - 1;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ~out_stall;
    endcase
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time,
               expected_remainders.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin : stimulus
    rrhf_pkg::floor_t floor_plan [5];
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_item          = '0;
    out_stall        = 1'b0;
    cfg_valid        = 1'b0;
    cfg_min_hit_size = rrhf_pkg::FLOOR_RESET;
    floor_model      = rrhf_pkg::FLOOR_RESET;
    error_count      = 0;
    results_checked  = 0;
    floor_clears     = 0;
    empty_remainders = 0;
    settings_used    = 1;
    cycle_count      = 0;
    burst_left       = 1;
    gap_left         = 0;
    stall_mode       = 0;
    stall_mode_left  = 0;
    floor_plan = '{rrhf_pkg::floor_t'(0), rrhf_pkg::floor_t'(4095), rrhf_pkg::floor_t'(1),
                   rrhf_pkg::floor_t'(0), rrhf_pkg::FLOOR_RESET};
    floor_plan[3] = rrhf_pkg::floor_t'($urandom_range(2, 4094));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed cases at the reset floor
    // disjoint, touching on one column, enclosed, identical
    pending_queries.push_back(pack_query(0, 0, 99, 99, 200, 200, 300, 300));
    pending_queries.push_back(pack_query(0, 0, 99, 99, 99, 0, 199, 99));
    pending_queries.push_back(pack_query(0, 0, 99, 99, -5, -5, 120, 120));
    pending_queries.push_back(pack_query(0, 0, 99, 99, 0, 0, 99, 99));
    // four-way tie, then each single slice, then a clear winner on the right
    pending_queries.push_back(pack_query(0, 0, 99, 99, 10, 10, 89, 89));
    pending_queries.push_back(pack_query(0, 0, 99, 99, 0, 0, 99, 9));
    pending_queries.push_back(pack_query(0, 0, 99, 99, 0, 80, 99, 99));
    pending_queries.push_back(pack_query(0, 0, 99, 99, 70, 0, 99, 99));
    pending_queries.push_back(pack_query(0, 0, 99, 99, 0, 0, 20, 99));
    pending_queries.push_back(pack_query(0, 0, 99, 99, 30, 40, 35, 45));
    // full-range object against point and full-range covers
    pending_queries.push_back(pack_query(-32768, -32768, 32767, 32767, 0, 0, 0, 0));
    pending_queries.push_back(pack_query(-32768, -32768, 32767, 32767,
                                         -32768, -32768, 32767, 32767));
    pending_queries.push_back(pack_query(-32768, -32768, 32767, 32767,
                                         32767, 32767, 32767, 32767));
    pending_queries.push_back(pack_query(-32768, -32768, 32767, 32767,
                                         -32768, -32768, -32768, -32768));
    // inverted object, inverted cover, negative slice areas
    pending_queries.push_back(pack_query(10, 10, 0, 0, 5, 5, 5, 5));
    pending_queries.push_back(pack_query(0, 0, 99, 99, 50, 50, 40, 40));
    pending_queries.push_back(pack_query(0, 50, 99, 10, 20, 0, 30, 60));
    // exactly at the floor and one short in each direction
    pending_queries.push_back(pack_query(0, 0, 43, 43, 100, 100, 110, 110));
    pending_queries.push_back(pack_query(0, 0, 42, 43, 100, 100, 110, 110));
    pending_queries.push_back(pack_query(0, 0, 43, 42, 100, 100, 110, 110));
    // slices against the range limits
    pending_queries.push_back(pack_query(32700, 32700, 32767, 32767,
                                         32767, -32768, 32767, 32767));
    pending_queries.push_back(pack_query(-32768, -100, -32700, -1,
                                         -32768, -50, -32768, -50));
    wait_idle();

    // Random phases, one per floor setting
    foreach (floor_plan[p]) begin
      write_floor(floor_plan[p]);
      @(negedge clk);
      repeat (ITEMS_PER_PHASE) pending_queries.push_back(random_query(floor_plan[p]));
      wait_idle();
    end

    repeat (8) @(posedge clk);
    $display("Checked %0d remainder beats over %0d min_hit_size settings (0 and 4095 included).",
             results_checked, settings_used);
    $display("%0d cleared the floor, %0d came back as the empty rectangle.",
             floor_clears, empty_remainders);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
